FILE: src/tss_pkg.sv
// Shared types, constants and fault-bit masks for the traction safety supervisor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tss_pkg;

  // Fault vector geometry
  localparam int FaultBits        = 16;
  localparam int WatchdogBit      = 0;
  localparam int PrechargeFailBit = 1;

  localparam int FaultW = 16;
  localparam int TimerW = 16;
  localparam int ThrW   = 12;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 3;

  // Fault bits that survive: below FaultBits and below the 16-bit field
  localparam logic [FaultW-1:0] FaultKeep =
    (FaultBits >= FaultW) ? {FaultW{1'b1}} : FaultW'((32'd1 << FaultBits) - 32'd1);

  localparam logic [FaultW-1:0] WatchdogMask =
    (WatchdogBit < FaultW) ? (FaultW'(1) << WatchdogBit) & FaultKeep : '0;

  localparam logic [FaultW-1:0] PrechargeFailMask =
    (PrechargeFailBit < FaultW) ? (FaultW'(1) << PrechargeFailBit) & FaultKeep : '0;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  // Supervisor modes
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_BOOT     = 3'd1,
    MODE_SELFTEST = 3'd2,
    MODE_READY    = 3'd3,
    MODE_ARMED    = 3'd4,
    MODE_DRIVING  = 3'd5,
    MODE_FAULT    = 3'd6,
    MODE_SHUTDOWN = 3'd7
  } tss_mode_e;

  typedef enum logic [1:0] {
    CONT_OPEN      = 2'd0,
    CONT_PRECHARGE = 2'd1,
    CONT_CLOSE     = 2'd2
  } tss_cont_e;

  typedef enum logic [1:0] {
    MSG_NONE     = 2'd0,
    MSG_FAULT    = 2'd1,
    MSG_SHUTDOWN = 2'd2
  } tss_msg_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SELF_TEST_TICKS   = 3'd0,
    CFG_PRECHARGE_TICKS   = 3'd1,
    CFG_SHUTDOWN_TICKS    = 3'd2,
    CFG_THROTTLE_DEADBAND = 3'd3,
    CFG_CRITICAL_MASK     = 3'd4,
    CFG_BLOCKING_MASK     = 3'd5,
    CFG_LATCHING_MASK     = 3'd6
  } tss_cfg_idx_e;

  typedef struct packed {
    logic [TimerW-1:0] self_test_ticks;
    logic [TimerW-1:0] precharge_ticks;
    logic [TimerW-1:0] shutdown_ticks;
    logic [ThrW-1:0]   throttle_deadband;
    logic [FaultW-1:0] critical_mask;
    logic [FaultW-1:0] blocking_mask;
    logic [FaultW-1:0] latching_mask;
  } tss_cfg_t;

  typedef struct packed {
    tss_mode_e         mode;
    logic [FaultW-1:0] fault_latch;
    logic [TimerW-1:0] mode_timer;
    logic [TimerW-1:0] precharge_timer;
    logic [TimerW-1:0] shutdown_timer;
  } tss_state_t;

  // Input beat
  typedef struct packed {
    logic [FaultW-1:0] fault_bits;
    logic              pwr_cycle;
    logic              pwr_on_req;
    logic              arm_req;
    logic              drv_auth;
    logic              brake_on;
    logic              precharge_good;
    logic [ThrW-1:0]   throttle_level;
    logic              disarm_req;
    logic              fault_ack;
  } tss_in_t;

  // Result beat
  typedef struct packed {
    logic [2:0]        sup_mode;
    logic [1:0]        contactor_cmd;
    logic              torque_permitted;
    logic              regen_ok;
    logic [FaultW-1:0] fault_active;
    logic [FaultW-1:0] latched_faults;
    logic [1:0]        message_code;
  } tss_out_t;

  // Saturating tick counter increment
  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] t);
    sat_inc = (t == TimerMax) ? TimerMax : t + TimerW'(1);
  endfunction

endpackage

`default_nettype wire

FILE: src/tss_in_if.sv
// Valid/ready channel carrying one input tick of the supervisor.
// Depends on tss_pkg for the payload type.
`default_nettype none

interface tss_in_if;
  import tss_pkg::*;

  logic    valid;
  logic    ready;
  tss_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tss_out_if.sv
// Valid/ready channel carrying one result of the supervisor.
// Depends on tss_pkg for the payload type.
`default_nettype none

interface tss_out_if;
  import tss_pkg::*;

  logic     valid;
  logic     ready;
  tss_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tss_cfg_regs.sv
// Configuration register file of the supervisor: write-only, indexed port.
// Depends on tss_pkg for the register indexes and the bundle type.
`default_nettype none

module tss_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tss_pkg::CfgW-1:0]    cfg_data_i,
  output tss_pkg::tss_cfg_t                cfg_o
);
  import tss_pkg::*;

  tss_cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SELF_TEST_TICKS:   cfg_d.self_test_ticks   = cfg_data_i[TimerW-1:0];
        CFG_PRECHARGE_TICKS:   cfg_d.precharge_ticks   = cfg_data_i[TimerW-1:0];
        CFG_SHUTDOWN_TICKS:    cfg_d.shutdown_ticks    = cfg_data_i[TimerW-1:0];
        CFG_THROTTLE_DEADBAND: cfg_d.throttle_deadband = cfg_data_i[ThrW-1:0];
        CFG_CRITICAL_MASK:     cfg_d.critical_mask     = cfg_data_i[FaultW-1:0];
        CFG_BLOCKING_MASK:     cfg_d.blocking_mask     = cfg_data_i[FaultW-1:0];
        CFG_LATCHING_MASK:     cfg_d.latching_mask     = cfg_data_i[FaultW-1:0];
        default: ;
      endcase
    end
  end

  // Hold register values, load defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_test_ticks   <= TimerW'(100);
      cfg_q.precharge_ticks   <= TimerW'(200);
      cfg_q.shutdown_ticks    <= TimerW'(500);
      cfg_q.throttle_deadband <= ThrW'(205);
      cfg_q.critical_mask     <= '0;
      cfg_q.blocking_mask     <= '0;
      cfg_q.latching_mask     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/tss_step.sv
// One supervisor tick: fault merge and classing, mode transition, timers, result.
// Purely combinational; depends on tss_pkg.
`default_nettype none

module tss_step (
  input  tss_pkg::tss_in_t    in_i,
  input  tss_pkg::tss_cfg_t   cfg_i,
  input  tss_pkg::tss_state_t state_i,
  output tss_pkg::tss_state_t state_o,
  output tss_pkg::tss_out_t   res_o
);
  import tss_pkg::*;

  logic [FaultW-1:0] detected;
  logic [FaultW-1:0] active_base;
  logic [FaultW-1:0] latched_base;
  logic [FaultW-1:0] latch_set;
  logic [FaultW-1:0] active;
  logic [FaultW-1:0] latched;
  logic [TimerW-1:0] mt_inc;
  logic [TimerW-1:0] pt_inc;
  logic [TimerW-1:0] sd_inc;
  logic              critical;
  logic              blocking;
  logic              pc_phase;
  logic              go_drive;
  logic              stop_drive;
  tss_mode_e         mode_d;
  tss_cont_e         cont;
  tss_msg_e          msg;
  logic              drive;

  // Merge and class faults
  always_comb begin
    detected     = in_i.fault_bits & FaultKeep;
    active_base  = in_i.pwr_cycle ? detected
                                  : (detected | (state_i.fault_latch & FaultKeep));
    latched_base = in_i.pwr_cycle ? '0 : (state_i.fault_latch & FaultKeep);
    critical     = |(active_base & cfg_i.critical_mask);
    blocking     = |(active_base & cfg_i.blocking_mask);
    latch_set    = active_base & cfg_i.critical_mask & cfg_i.latching_mask;
    mt_inc       = sat_inc(state_i.mode_timer);
    pt_inc       = sat_inc(state_i.precharge_timer);
    sd_inc       = sat_inc(state_i.shutdown_timer);
    pc_phase     = pt_inc < cfg_i.precharge_ticks;
    go_drive     = (in_i.throttle_level > cfg_i.throttle_deadband) && !in_i.brake_on;
    stop_drive   = in_i.disarm_req || in_i.brake_on;
  end

  // Next mode, timers and latch
  always_comb begin
    mode_d                  = state_i.mode;
    latched                 = latched_base;
    state_o.mode_timer      = mt_inc;
    state_o.precharge_timer = state_i.precharge_timer;
    state_o.shutdown_timer  = state_i.shutdown_timer;
    case (state_i.mode)
      MODE_OFF: begin
        if (in_i.pwr_on_req) begin
          mode_d = MODE_BOOT;
          state_o.mode_timer = '0;
        end
      end
      MODE_BOOT: begin
        if (|(active_base & WatchdogMask)) begin
          latched = latched_base | WatchdogMask;
          mode_d  = MODE_FAULT;
        end else if (mt_inc >= TimerW'(1)) begin
          mode_d = MODE_SELFTEST;
          state_o.mode_timer = '0;
        end
      end
      MODE_SELFTEST: begin
        if (critical || blocking) begin
          mode_d = MODE_FAULT;
        end else if (mt_inc >= cfg_i.self_test_ticks) begin
          mode_d = MODE_READY;
          state_o.mode_timer = '0;
        end
      end
      MODE_READY, MODE_ARMED, MODE_DRIVING: begin
        if (critical) begin
          latched = latched_base | latch_set;
          mode_d  = MODE_SHUTDOWN;
          state_o.shutdown_timer = '0;
        end else if (blocking) begin
          mode_d = MODE_FAULT;
        end else if (state_i.mode == MODE_READY) begin
          if (in_i.arm_req && in_i.drv_auth && in_i.brake_on) begin
            state_o.precharge_timer = '0;
            mode_d = MODE_ARMED;
            state_o.mode_timer = '0;
          end
        end else if (state_i.mode == MODE_ARMED) begin
          state_o.precharge_timer = pt_inc;
          if (pc_phase) begin
            if (!in_i.precharge_good) begin
              latched = latched_base | PrechargeFailMask;
              mode_d  = MODE_SHUTDOWN;
              state_o.shutdown_timer = '0;
            end
          end else if (go_drive) begin
            mode_d = MODE_DRIVING;
            state_o.mode_timer = '0;
          end
        end else begin
          if (stop_drive) begin
            mode_d = MODE_READY;
            state_o.mode_timer = '0;
          end
        end
      end
      MODE_FAULT: begin
        if (critical) begin
          latched = latched_base | latch_set;
          mode_d  = MODE_SHUTDOWN;
          state_o.shutdown_timer = '0;
        end else if (!blocking && in_i.fault_ack) begin
          mode_d = MODE_READY;
          state_o.mode_timer = '0;
        end
      end
      MODE_SHUTDOWN: begin
        state_o.shutdown_timer = sd_inc;
        if (sd_inc >= cfg_i.shutdown_ticks) begin
          mode_d = MODE_OFF;
        end
      end
      default: ;
    endcase
    state_o.mode        = mode_d;
    state_o.fault_latch = latched & FaultKeep;
  end

  // Contactor, permits, active faults and message for this tick
  always_comb begin
    cont   = CONT_OPEN;
    drive  = 1'b0;
    msg    = MSG_NONE;
    active = active_base;
    case (state_i.mode)
      MODE_ARMED: begin
        if (!critical && !blocking) begin
          if (pc_phase) begin
            if (!in_i.precharge_good) begin
              active = active_base | PrechargeFailMask;
            end else begin
              cont = CONT_PRECHARGE;
            end
          end else begin
            cont = CONT_CLOSE;
          end
        end
      end
      MODE_DRIVING: begin
        if (!critical && !blocking && !stop_drive) begin
          cont  = CONT_CLOSE;
          drive = 1'b1;
        end
      end
      MODE_FAULT:    msg = MSG_FAULT;
      MODE_SHUTDOWN: msg = MSG_SHUTDOWN;
      default: ;
    endcase
  end

  // Pack the result beat
  always_comb begin
    res_o.sup_mode         = mode_d;
    res_o.contactor_cmd    = cont;
    res_o.torque_permitted = drive;
    res_o.regen_ok         = drive;
    res_o.fault_active     = active;
    res_o.latched_faults   = latched & FaultKeep;
    res_o.message_code     = msg;
  end

endmodule

`default_nettype wire

FILE: src/traction_safety_supervisor.sv
// Top level of the traction safety supervisor: config registers, state and result register.
// Depends on tss_pkg, tss_in_if, tss_out_if, tss_cfg_regs and tss_step.
//
//   channel   dir  handshake          beat
//   in_if     in   valid/ready        one tick: fault bits, requests, feedback, throttle
//   out_if    out  valid/ready        one result: mode, contactor, permits, faults, message
//   cfg_*     in   write enable only  register index and 16-bit data
//
// Each tick is worked out in the cycle it is accepted and shows on out_if at the next
// edge; one beat per cycle is sustained while out_if.ready stays high.
// The result register is the only stage; in_if.ready drops only while a result waits
// and out_if.ready is low.
// Reset loads the register defaults, clears the mode (off), the latch and all timers.
`default_nettype none

module traction_safety_supervisor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tss_pkg::CfgW-1:0]    cfg_data_i,
  tss_in_if.sink                           in_if,
  tss_out_if.source                        out_if
);
  import tss_pkg::*;

  tss_cfg_t   cfg;
  tss_state_t state_q, state_d;
  tss_out_t   res_d, res_q;
  logic       out_valid_q;
  logic       in_fire;

  tss_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tss_step u_step (
    .in_i    (in_if.data),
    .cfg_i   (cfg),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Take a beat whenever the result slot is free or being emptied
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // Advance the supervisor state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_OFF, default: '0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = res_q;

endmodule

`default_nettype wire
